### rtl/core/sv39_page_table_walker_macros.svh
`ifndef SV39_PAGE_TABLE_WALKER_MACROS_SVH
`define SV39_PAGE_TABLE_WALKER_MACROS_SVH

// Same-cycle implication, off during reset.
`define SV39_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define SV39_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/sv39ptw_pkg.sv
package sv39ptw_pkg;

  localparam int PTE_W      = 64;
  localparam int PPN_W      = 44;
  localparam int PPN_LSB    = 10;
  localparam int PA_W       = 56;
  localparam int FLAG_W     = 10;
  localparam int SLOT_W     = 9;
  localparam int PAGE_SHIFT = 12;
  localparam int VALID_BIT  = 0;
  localparam int IDX_W      = 12;

  // Remainder unit: bits folded per cycle and chunks per PPN
  localparam int RED_BITS  = 8;
  localparam int RED_STEPS = (PPN_W + RED_BITS - 1) / RED_BITS;
  localparam int RED_CNT_W = $clog2(RED_STEPS);

  // APB register file
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 64;
  localparam logic CFG_IDX_ROOT = 1'b0;

  localparam logic REQ_TRANSLATE = 1'b0;
  localparam logic REQ_WRITE     = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_CHECK,
    ST_HOLD
  } state_t;

endpackage

### rtl/core/sv39_page_table_walker.sv
// Sv39 page-table walker with its own page-table store.
// Input channel (in_valid/in_ready): req_type 1 writes entry_value at
// entry_index (ignored beyond the store); req_type 0 translates virt_addr.
// Result channel (out_valid/out_ready): one item per input item. A write
// returns all zeros. A translation returns the leaf PPN shifted to a page
// base plus the leaf's low ten flag bits, or fault=1 with zero fields when
// virt_addr >= 2^38 or any entry on the walk has its valid bit clear.
// Walk: the store is read once per level. With TABLE_PAGES a power of
// two the first read is issued on accept and each further read by the
// entry check of the level above; writes and range faults finish on
// accept.
// Otherwise each level first folds the PPN modulo TABLE_PAGES, 8 bits per
// cycle, before its read.
// One item is in flight at a time; in_ready is high only when idle.
// Reset: after rst_n the store is swept to zero, one entry per cycle,
// all TABLE_PAGES*512 entries (4096 by default), with in_ready low. APB
// writes to root_table_ppn (addresses 0 to 7) are taken at any time.
// Stall: a result waiting on out_ready sits in the output register; the
// next item is still accepted and its result parks until the register frees.
`include "sv39_page_table_walker_macros.svh"

module sv39_page_table_walker #(
  parameter int TABLE_PAGES = 8,
  parameter int LEVELS      = 3
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_req_type,
  input  logic [63:0]                          in_virt_addr,
  input  logic [sv39ptw_pkg::IDX_W-1:0]        in_entry_index,
  input  logic [sv39ptw_pkg::PTE_W-1:0]        in_entry_value,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [sv39ptw_pkg::PA_W-1:0]         out_phys_page_addr,
  output logic                                 out_fault,
  output logic [sv39ptw_pkg::FLAG_W-1:0]       out_leaf_flags,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [sv39ptw_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [sv39ptw_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [sv39ptw_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                 pready
);

  localparam int SLOTS   = 1 << sv39ptw_pkg::SLOT_W;
  localparam int DEPTH   = TABLE_PAGES * SLOTS;
  localparam int AW      = $clog2(DEPTH);
  localparam int PW      = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam bit IS_POW2 = (TABLE_PAGES & (TABLE_PAGES - 1)) == 0;
  localparam int LW      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int VPN_W   = sv39ptw_pkg::SLOT_W * LEVELS;
  localparam int VA_TOP  = sv39ptw_pkg::PAGE_SHIFT + VPN_W - 1;
  localparam int RED_W   = sv39ptw_pkg::RED_BITS * sv39ptw_pkg::RED_STEPS;

  localparam int PTE_W  = sv39ptw_pkg::PTE_W;
  localparam int PPN_W  = sv39ptw_pkg::PPN_W;
  localparam int PA_W   = sv39ptw_pkg::PA_W;
  localparam int FLAG_W = sv39ptw_pkg::FLAG_W;
  localparam int SLOT_W = sv39ptw_pkg::SLOT_W;
  localparam int CNT_W  = sv39ptw_pkg::RED_CNT_W;

  // state and walk registers
  sv39ptw_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]     clr_idx_r, clr_idx_nxt;
  logic [LW-1:0]     level_r, level_nxt;
  logic [VPN_W-1:0]  vpn_r, vpn_nxt;
  logic [PPN_W-1:0]  ppn_r, ppn_nxt;
  logic [PW-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PPN_W-1:0]  root_r;

  // output register and parked result
  logic              out_valid_r, out_valid_nxt;
  logic [PA_W-1:0]   out_phys_r, out_phys_nxt;
  logic              out_fault_r, out_fault_nxt;
  logic [FLAG_W-1:0] out_flags_r, out_flags_nxt;
  logic [PA_W-1:0]   pend_phys_r, pend_phys_nxt;
  logic              pend_fault_r, pend_fault_nxt;
  logic [FLAG_W-1:0] pend_flags_r, pend_flags_nxt;

  // store
  logic [PTE_W-1:0]  pte_mem [DEPTH];
  logic [PTE_W-1:0]  rd_data_r;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_wa, mem_ra;
  logic [PTE_W-1:0]  mem_wd;

  // finishing result
  logic              fin;
  logic              fin_fault;
  logic [PA_W-1:0]   fin_phys;
  logic [FLAG_W-1:0] fin_flags;
  logic              can_load;

  // remainder unit
  logic [RED_W-1:0]  ppn_pad;
  logic [sv39ptw_pkg::RED_BITS-1:0] red_chunk;
  logic [PW-1:0]     red_rem;
  logic [SLOT_W-1:0] cur_slot;
  logic [SLOT_W-1:0] down_slot;
  logic [PPN_W-1:0]  rd_ppn;

  function automatic logic [PW-1:0] pow2_page(input logic [PPN_W-1:0] ppn);
    pow2_page = PW'(ppn) & PW'(TABLE_PAGES - 1);
  endfunction

  function automatic logic [AW-1:0] mk_addr(input logic [PW-1:0] page,
                                            input logic [SLOT_W-1:0] slot);
    mk_addr = AW'({page, slot});
  endfunction

  assign in_ready = (state_r == sv39ptw_pkg::ST_IDLE);
  assign can_load = !out_valid_r || out_ready;
  assign rd_ppn   = rd_data_r[sv39ptw_pkg::PPN_LSB +: PPN_W];
  assign cur_slot = SLOT_W'(vpn_r >> (SLOT_W * int'(level_r)));
  assign down_slot = SLOT_W'(vpn_r >> (SLOT_W * (int'(level_r) - 1)));

  // fold the PPN one chunk per cycle: rem = (rem * 2 + bit) mod TABLE_PAGES
  always_comb begin
    logic [PW:0] red_t;
    ppn_pad   = RED_W'(ppn_r);
    red_chunk = sv39ptw_pkg::RED_BITS'(ppn_pad >>
                (sv39ptw_pkg::RED_BITS * (sv39ptw_pkg::RED_STEPS - 1 - int'(cnt_r))));
    red_rem   = rem_r;
    for (int b = sv39ptw_pkg::RED_BITS - 1; b >= 0; b--) begin
      red_t = {red_rem, red_chunk[b]};
      if (red_t >= (PW + 1)'(TABLE_PAGES)) begin
        red_t = red_t - (PW + 1)'(TABLE_PAGES);
      end
      red_rem = red_t[PW-1:0];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    level_nxt      = level_r;
    vpn_nxt        = vpn_r;
    ppn_nxt        = ppn_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    mem_we         = 1'b0;
    mem_wa         = '0;
    mem_wd         = '0;
    mem_re         = 1'b0;
    mem_ra         = '0;
    fin            = 1'b0;
    fin_fault      = 1'b0;
    fin_phys       = '0;
    fin_flags      = '0;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_phys_nxt   = out_phys_r;
    out_fault_nxt  = out_fault_r;
    out_flags_nxt  = out_flags_r;
    pend_phys_nxt  = pend_phys_r;
    pend_fault_nxt = pend_fault_r;
    pend_flags_nxt = pend_flags_r;

    case (state_r)
      sv39ptw_pkg::ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_wa      = clr_idx_r;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == AW'(DEPTH - 1)) begin
          state_nxt = sv39ptw_pkg::ST_IDLE;
        end
      end
      sv39ptw_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_req_type == sv39ptw_pkg::REQ_WRITE) begin
            if (32'(in_entry_index) < 32'(DEPTH)) begin
              mem_we = 1'b1;
              mem_wa = AW'(in_entry_index);
              mem_wd = in_entry_value;
            end
            fin = 1'b1;
          end else if (in_virt_addr[63:VA_TOP] != '0) begin
            fin       = 1'b1;
            fin_fault = 1'b1;
          end else begin
            vpn_nxt   = in_virt_addr[sv39ptw_pkg::PAGE_SHIFT +: VPN_W];
            level_nxt = LW'(LEVELS - 1);
            ppn_nxt   = root_r;
            if (IS_POW2) begin
              mem_re    = 1'b1;
              mem_ra    = mk_addr(pow2_page(root_r),
                                  in_virt_addr[VA_TOP - SLOT_W + 1 +: SLOT_W]);
              state_nxt = sv39ptw_pkg::ST_CHECK;
            end else begin
              rem_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = sv39ptw_pkg::ST_REDUCE;
            end
          end
        end
      end
      sv39ptw_pkg::ST_REDUCE: begin
        rem_nxt = red_rem;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(sv39ptw_pkg::RED_STEPS - 1)) begin
          mem_re    = 1'b1;
          mem_ra    = mk_addr(red_rem, cur_slot);
          state_nxt = sv39ptw_pkg::ST_CHECK;
        end
      end
      sv39ptw_pkg::ST_CHECK: begin
        if (!rd_data_r[sv39ptw_pkg::VALID_BIT]) begin
          fin       = 1'b1;
          fin_fault = 1'b1;
        end else if (level_r == '0) begin
          fin       = 1'b1;
          fin_phys  = {rd_ppn, {sv39ptw_pkg::PAGE_SHIFT{1'b0}}};
          fin_flags = rd_data_r[FLAG_W-1:0];
        end else begin
          // descend one level
          ppn_nxt   = rd_ppn;
          level_nxt = level_r - 1'b1;
          if (IS_POW2) begin
            mem_re = 1'b1;
            mem_ra = mk_addr(pow2_page(rd_ppn), down_slot);
          end else begin
            rem_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = sv39ptw_pkg::ST_REDUCE;
          end
        end
      end
      sv39ptw_pkg::ST_HOLD: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_phys_nxt  = pend_phys_r;
          out_fault_nxt = pend_fault_r;
          out_flags_nxt = pend_flags_r;
          state_nxt     = sv39ptw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sv39ptw_pkg::ST_IDLE;
      end
    endcase

    // load the output register, or park the result while it is taken
    if (fin) begin
      if (can_load) begin
        out_valid_nxt = 1'b1;
        out_phys_nxt  = fin_phys;
        out_fault_nxt = fin_fault;
        out_flags_nxt = fin_flags;
        state_nxt     = sv39ptw_pkg::ST_IDLE;
      end else begin
        pend_phys_nxt  = fin_phys;
        pend_fault_nxt = fin_fault;
        pend_flags_nxt = fin_flags;
        state_nxt      = sv39ptw_pkg::ST_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sv39ptw_pkg::ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    level_r      <= level_nxt;
    vpn_r        <= vpn_nxt;
    ppn_r        <= ppn_nxt;
    rem_r        <= rem_nxt;
    cnt_r        <= cnt_nxt;
    out_phys_r   <= out_phys_nxt;
    out_fault_r  <= out_fault_nxt;
    out_flags_r  <= out_flags_nxt;
    pend_phys_r  <= pend_phys_nxt;
    pend_fault_r <= pend_fault_nxt;
    pend_flags_r <= pend_flags_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pte_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= pte_mem[mem_ra];
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[sv39ptw_pkg::CFG_ADDR_W-1] == sv39ptw_pkg::CFG_IDX_ROOT) begin
      root_r <= pwdata[PPN_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[sv39ptw_pkg::CFG_ADDR_W-1] == sv39ptw_pkg::CFG_IDX_ROOT) ?
                  sv39ptw_pkg::CFG_DATA_W'(root_r) : '0;

  assign out_valid          = out_valid_r;
  assign out_phys_page_addr = out_phys_r;
  assign out_fault          = out_fault_r;
  assign out_leaf_flags     = out_flags_r;

  `SV39_ASSERT_NOW(a_fault_zero, clk, rst_n, out_valid_r && out_fault_r, out_phys_r == '0 && out_flags_r == '0, "fault result carries nonzero fields")
  `SV39_ASSERT_NEXT(a_read_then_check, clk, rst_n, mem_re, state_r == sv39ptw_pkg::ST_CHECK, "store read not followed by entry check")
  `SV39_ASSERT_NOW(a_rem_range, clk, rst_n, state_r == sv39ptw_pkg::ST_REDUCE, 32'(rem_r) < 32'(TABLE_PAGES), "page remainder out of range")
  `SV39_ASSERT_NOW(a_level_range, clk, rst_n, state_r == sv39ptw_pkg::ST_CHECK, 32'(level_r) < 32'(LEVELS), "walk level out of range")

endmodule
